// File: sv/bchd_pkg.sv
// Shared types and constants for the button click and holddown detector.
package bchd_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CfgW   = 16;
  localparam int unsigned BtnW   = 3;
  localparam int unsigned ClickW = 8;
  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgW-1:0] IgnoreReset = 16'd50;
  localparam logic [CfgW-1:0] DoubleReset = 16'd250;
  localparam logic [CfgW-1:0] HoldReset   = 16'd3000;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IGNORE = 2'd0,
    CFG_DOUBLE = 2'd1,
    CFG_HOLD   = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgW-1:0] ignore_ms;
    logic [CfgW-1:0] double_click_ms;
    logic [CfgW-1:0] holddown_ms;
  } cfg_t;

  typedef struct packed {
    logic [BtnW-1:0]  button;
    logic             pressed;
    logic [TimeW-1:0] now_ms;
  } item_t;

  typedef struct packed {
    logic [BtnW-1:0]   button_id;
    logic              press_event;
    logic              release_event;
    logic              count_valid;
    logic [ClickW-1:0] click_count;
    logic              holddown_event;
  } res_t;

endpackage

// File: sv/bchd_front.sv
// Input stage: takes samples, drops out-of-range buttons and queues the rest.
module bchd_front import bchd_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  item_t in_item_i,
  output logic  item_valid_o,
  output item_t item_o,
  input  logic  pop_i
);

  item_t      mem_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  logic       in_range;
  logic       push;
  logic       pop;

  assign in_range     = 32'(in_item_i.button) < NUM_BUTTONS;
  assign in_ready_o   = (cnt_q != 2'd2);
  assign push         = in_valid_i && in_ready_o && in_range;
  assign item_valid_o = (cnt_q != 2'd0);
  assign pop          = pop_i && item_valid_o;
  assign item_o       = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= in_item_i;
    end
  end

endmodule

// File: sv/bchd_back.sv
// Event stage: per-button state update and registered result.
module bchd_back import bchd_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  cfg_t  cfg_i,
  input  logic  item_valid_i,
  input  item_t item_i,
  output logic  pop_o,
  output logic  out_valid_o,
  input  logic  out_ready_i,
  output res_t  res_o
);

  localparam int unsigned NumSt = (NUM_BUTTONS > 8) ? 8 : NUM_BUTTONS;
  localparam int unsigned IdxW  = (NumSt > 1) ? $clog2(NumSt) : 1;

  logic [NumSt-1:0]  down_q;
  logic [NumSt-1:0]  pend_q;
  logic [NumSt-1:0]  armed_q;
  logic [TimeW-1:0]  rel_time_q   [NumSt];
  logic [TimeW-1:0]  press_time_q [NumSt];
  logic [ClickW-1:0] clicks_q     [NumSt];

  logic [IdxW-1:0]   idx;
  logic              dn, pd, am;
  logic [TimeW-1:0]  rt, pt;
  logic [ClickW-1:0] ck;
  logic [TimeW-1:0]  d_rel, d_prs;
  logic              ev_press, ev_rel, ev_cnt, ev_hold, quiet, any_ev;
  logic              dn_d, pend_d, armed_d;
  logic [TimeW-1:0]  rt_d, pt_d;
  logic [ClickW-1:0] ck_d;
  logic              out_valid_q, out_valid_d;
  res_t              res_q, res_d;

  assign idx = item_i.button[IdxW-1:0];
  assign dn  = down_q[idx];
  assign pd  = pend_q[idx];
  assign am  = armed_q[idx];
  assign rt  = rel_time_q[idx];
  assign pt  = press_time_q[idx];
  assign ck  = clicks_q[idx];

  assign pop_o = item_valid_i && (!out_valid_q || out_ready_i);

  always_comb begin
    d_rel    = item_i.now_ms - rt;
    d_prs    = item_i.now_ms - pt;
    ev_press = item_i.pressed && !dn &&
               !(pd && (d_rel < {16'd0, cfg_i.ignore_ms}));
    ev_rel   = !item_i.pressed && dn;
    quiet    = pd && !dn && !ev_press && (d_rel > {16'd0, cfg_i.double_click_ms});
    ev_cnt   = quiet && am;
    ev_hold  = item_i.pressed && dn && am && (d_prs > {16'd0, cfg_i.holddown_ms});
    any_ev   = ev_press || ev_rel || ev_cnt || ev_hold;

    dn_d    = ev_press || (dn && !ev_rel);
    pt_d    = ev_press ? item_i.now_ms : pt;
    armed_d = (ev_press || am) && !ev_hold;
    rt_d    = ev_rel ? item_i.now_ms : rt;
    pend_d  = ev_rel || (pd && !quiet);
    if (ev_rel) begin
      ck_d = (ck == 8'hFF) ? ck : ck + 8'd1;
    end else if (quiet) begin
      ck_d = '0;
    end else begin
      ck_d = ck;
    end

    res_d.button_id      = item_i.button;
    res_d.press_event    = ev_press;
    res_d.release_event  = ev_rel;
    res_d.count_valid    = ev_cnt;
    res_d.click_count    = ev_cnt ? ck : '0;
    res_d.holddown_event = ev_hold;

    if (pop_o) begin
      out_valid_d = any_ev;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      down_q      <= '0;
      pend_q      <= '0;
      armed_q     <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < NumSt; i++) begin
        rel_time_q[i]   <= '0;
        press_time_q[i] <= '0;
        clicks_q[i]     <= '0;
      end
    end else begin
      out_valid_q <= out_valid_d;
      if (pop_o) begin
        down_q[idx]       <= dn_d;
        pend_q[idx]       <= pend_d;
        armed_q[idx]      <= armed_d;
        rel_time_q[idx]   <= rt_d;
        press_time_q[idx] <= pt_d;
        clicks_q[idx]     <= ck_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o && any_ev) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

`ifndef SYNTHESIS
  a_result_has_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (res_q.press_event || res_q.release_event ||
                     res_q.count_valid || res_q.holddown_event))
    else $error("result without any event");
  a_count_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !res_q.count_valid) |-> (res_q.click_count == '0))
    else $error("click count set without a report");
  a_press_not_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.press_event && res_q.release_event))
    else $error("press and release in one result");
  a_press_not_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(res_q.press_event && res_q.holddown_event))
    else $error("press and holddown in one result");
`endif

endmodule

// File: sv/button_click_holddown_detector_top.sv
// Top level of the button click and holddown detector.
// Throughput: one sample per cycle, sustained, when the result side keeps up.
// A sample is held in the queue, then updates its button state, and any result is registered behind that.
// A two-entry queue separates sample intake from the per-button state update.
// Reset clears all button state at once and loads the configuration defaults.
// No clearing pass is needed after reset.
module button_click_holddown_detector_top import bchd_pkg::*; #(
  parameter int unsigned NUM_BUTTONS = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [BtnW-1:0]    button_i,
  input  logic               pressed_i,
  input  logic [TimeW-1:0]   now_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [BtnW-1:0]    button_id_o,
  output logic               press_event_o,
  output logic               release_event_o,
  output logic               count_valid_o,
  output logic [ClickW-1:0]  click_count_o,
  output logic               holddown_event_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [CfgW-1:0]    cfg_data_i
);

  cfg_t  cfg_q;
  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;
  res_t  res;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ignore_ms       <= IgnoreReset;
      cfg_q.double_click_ms <= DoubleReset;
      cfg_q.holddown_ms     <= HoldReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_IGNORE: cfg_q.ignore_ms       <= cfg_data_i;
        CFG_DOUBLE: cfg_q.double_click_ms <= cfg_data_i;
        CFG_HOLD:   cfg_q.holddown_ms     <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign in_item.button  = button_i;
  assign in_item.pressed = pressed_i;
  assign in_item.now_ms  = now_ms_i;

  bchd_front #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .in_item_i    (in_item),
    .item_valid_o (q_valid),
    .item_o       (q_item),
    .pop_i        (q_pop)
  );

  bchd_back #(
    .NUM_BUTTONS(NUM_BUTTONS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .item_valid_i (q_valid),
    .item_i       (q_item),
    .pop_o        (q_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .res_o        (res)
  );

  assign button_id_o      = res.button_id;
  assign press_event_o    = res.press_event;
  assign release_event_o  = res.release_event;
  assign count_valid_o    = res.count_valid;
  assign click_count_o    = res.click_count;
  assign holddown_event_o = res.holddown_event;

endmodule
